@@ sv/skf_pkg.sv @@
// shared types and constants for the scalar kalman filter core
`default_nettype none
package skf_pkg;

  localparam int COV_W     = 32;
  localparam int DEN_W     = COV_W + 1;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_COVARIANCE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_INITIAL_ESTIMATE   = 2'd3;

  // reset values in whole units, scaled by the fraction width at the top level
  localparam int RST_Q_UNITS = 1;
  localparam int RST_R_UNITS = 10;
  localparam int RST_P_UNITS = 1;
  localparam int RST_X_UNITS = 800;

  typedef struct packed {
    logic inv;
    logic cin;
  } alu_ctl_t;

endpackage
`default_nettype wire

@@ sv/scalar_kalman_filter_core.sv @@
// one-dimensional kalman filter core on a shared add/subtract unit
// steps: predict, gain denominator, gain divider (FRAC_BITS+1 steps), difference of sample
// and estimate (with a negate step when the sample lies below the estimate), shift-add multiply,
// estimate update, shift-add multiply for the covariance (FRAC_BITS+1 steps for each multiply)
// one sample at a time: next input taken only when idle, also while the previous result waits
// reset: synchronous active-low, loads register defaults and the initial estimate and covariance
`default_nettype none
module scalar_kalman_filter_core #(
  parameter  int SAMPLE_BITS = 12,
  parameter  int FRAC_BITS   = 16,
  localparam int EST_W  = SAMPLE_BITS + FRAC_BITS,
  localparam int GAIN_W = FRAC_BITS + 1,
  localparam int CFG_W  = (EST_W > skf_pkg::COV_W) ? EST_W : skf_pkg::COV_W,
  localparam int IN_TW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TW = ((EST_W + GAIN_W + skf_pkg::COV_W + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [IN_TW-1:0]                in_tdata,   // measurement
  input  wire logic [0:0]                      in_tuser,   // restart
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [OUT_TW-1:0]                    out_tdata,  // estimate, gain, covariance
  input  wire logic                            cfg_we,
  input  wire logic [skf_pkg::REG_IDX_W-1:0]   cfg_addr,
  input  wire logic [CFG_W-1:0]                cfg_data
);

  localparam int COV_W = skf_pkg::COV_W;
  localparam int DEN_W = skf_pkg::DEN_W;
  localparam int ALU_W = (EST_W > COV_W + 2) ? EST_W : COV_W + 2;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [COV_W-1:0] RST_Q =
    COV_W'(64'(skf_pkg::RST_Q_UNITS) << FRAC_BITS);
  localparam logic [COV_W-1:0] RST_R =
    COV_W'(64'(skf_pkg::RST_R_UNITS) << FRAC_BITS);
  localparam logic [COV_W-1:0] RST_P =
    COV_W'(64'(skf_pkg::RST_P_UNITS) << FRAC_BITS);
  localparam logic [EST_W-1:0] RST_X =
    EST_W'(64'(skf_pkg::RST_X_UNITS) << FRAC_BITS);
  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED, ST_DEN, ST_DIV, ST_DIFF, ST_NEG, ST_MUL, ST_MFIN, ST_UPD, ST_DONE
  } state_t;

  state_t                 state_r;
  logic [COV_W-1:0]       q_r, r_r, p0_r, p_r, pp_r;
  logic [EST_W-1:0]       x0_r, x_r;
  logic [SAMPLE_BITS-1:0] meas_r;
  logic [DEN_W-1:0]       den_r, rem_r;
  logic [GAIN_W-1:0]      q_bits_r, gain_r, mplier_r;
  logic [ALU_W-1:0]       mcand_r, hi_r;
  logic                   rnd_r, up_r, cov_phase_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  logic [EST_W-1:0]       out_est_r;
  logic [GAIN_W-1:0]      out_gain_r;
  logic [COV_W-1:0]       out_cov_r;

  logic [EST_W-1:0]       target;
  logic [ALU_W-1:0]       alu_a, alu_b;
  skf_pkg::alu_ctl_t      alu_ctl;
  logic [ALU_W:0]         alu_sum;
  logic                   alu_ge;

  assign target = {meas_r, {FRAC_BITS{1'b0}}};
  assign alu_ge = alu_sum[ALU_W];

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_ctl = '{inv: 1'b0, cin: 1'b0};
    case (state_r)
      ST_PRED: begin
        alu_a = ALU_W'(p_r);
        alu_b = ALU_W'(q_r);
      end
      ST_DEN: begin
        alu_a = ALU_W'(pp_r);
        alu_b = ALU_W'(r_r);
      end
      ST_DIV: begin
        alu_a   = (cnt_r == '0) ? ALU_W'(rem_r) : ALU_W'({rem_r, 1'b0});
        alu_b   = ALU_W'(den_r);
        alu_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      ST_DIFF: begin
        alu_a   = ALU_W'(target);
        alu_b   = ALU_W'(x_r);
        alu_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      ST_NEG: begin
        alu_a   = ALU_W'(x_r);
        alu_b   = ALU_W'(target);
        alu_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      ST_MUL: begin
        alu_a = hi_r;
        alu_b = mplier_r[0] ? mcand_r : '0;
      end
      ST_MFIN: begin
        alu_a   = hi_r;
        alu_b   = mplier_r[0] ? mcand_r : '0;
        alu_ctl = '{inv: 1'b0, cin: rnd_r};
      end
      ST_UPD: begin
        alu_a   = ALU_W'(x_r);
        alu_b   = hi_r;
        alu_ctl = '{inv: !up_r, cin: !up_r};
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  skf_alu #(
    .W (ALU_W)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .ctl (alu_ctl),
    .sum (alu_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= RST_Q;
      r_r         <= RST_R;
      p0_r        <= RST_P;
      x0_r        <= RST_X;
      p_r         <= RST_P;
      x_r         <= RST_X;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          skf_pkg::REG_PROCESS_NOISE:      q_r  <= cfg_data[COV_W-1:0];
          skf_pkg::REG_MEASUREMENT_NOISE:  r_r  <= cfg_data[COV_W-1:0];
          skf_pkg::REG_INITIAL_COVARIANCE: p0_r <= cfg_data[COV_W-1:0];
          skf_pkg::REG_INITIAL_ESTIMATE:   x0_r <= cfg_data[EST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            meas_r <= in_tdata[SAMPLE_BITS-1:0];
            if (in_tuser[0]) begin
              x_r <= x0_r;
              p_r <= p0_r;
            end
            state_r <= ST_PRED;
          end
        end
        ST_PRED: begin
          pp_r    <= alu_sum[COV_W] ? '1 : alu_sum[COV_W-1:0];
          state_r <= ST_DEN;
        end
        ST_DEN: begin
          den_r   <= alu_sum[DEN_W-1:0];
          rem_r   <= {1'b0, pp_r};
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r    <= alu_ge ? alu_sum[DEN_W-1:0] : alu_a[DEN_W-1:0];
          q_bits_r <= {q_bits_r[GAIN_W-2:0], alu_ge};
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(FRAC_BITS)) begin
            state_r <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          gain_r      <= (den_r == '0) ? '0 : q_bits_r;
          mplier_r    <= (den_r == '0) ? '0 : q_bits_r;
          hi_r        <= '0;
          cnt_r       <= '0;
          cov_phase_r <= 1'b0;
          up_r        <= alu_ge;
          if (alu_ge) begin
            mcand_r <= alu_sum[ALU_W-1:0];
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_NEG;
          end
        end
        ST_NEG: begin
          mcand_r <= alu_sum[ALU_W-1:0];
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          hi_r     <= alu_sum[ALU_W:1];
          rnd_r    <= alu_sum[0];
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
            state_r <= ST_MFIN;
          end
        end
        ST_MFIN: begin
          if (!cov_phase_r) begin
            hi_r    <= alu_sum[ALU_W-1:0];
            state_r <= ST_UPD;
          end else begin
            p_r     <= alu_sum[COV_W-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_UPD: begin
          x_r         <= alu_sum[EST_W-1:0];
          mcand_r     <= ALU_W'(pp_r);
          mplier_r    <= GAIN_ONE - gain_r;
          hi_r        <= '0;
          cnt_r       <= '0;
          cov_phase_r <= 1'b1;
          state_r     <= ST_MUL;
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_est_r   <= x_r;
            out_gain_r  <= gain_r;
            out_cov_r   <= p_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({out_cov_r, out_gain_r, out_est_r});

endmodule
`default_nettype wire

@@ sv/skf_alu.sv @@
// shared add/subtract unit with carry out
`default_nettype none
module skf_alu #(
  parameter int W = 34
) (
  input  wire logic            [W-1:0] a,
  input  wire logic            [W-1:0] b,
  input  wire skf_pkg::alu_ctl_t       ctl,
  output logic                 [W:0]   sum
);

  logic [W-1:0] b_eff;

  assign b_eff = ctl.inv ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + (W+1)'(ctl.cin);

endmodule
`default_nettype wire

@@ sv/skf_checker.sv @@
// port-level checks for the scalar kalman filter core
`default_nettype none
module skf_checker #(
  parameter  int SAMPLE_BITS = 12,
  parameter  int FRAC_BITS   = 16,
  localparam int EST_W  = SAMPLE_BITS + FRAC_BITS,
  localparam int GAIN_W = FRAC_BITS + 1,
  localparam int OUT_TW = ((EST_W + GAIN_W + skf_pkg::COV_W + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_TW-1:0] out_tdata
);

  logic [GAIN_W-1:0] gain_w;
  logic              in_xfer;

  assign gain_w  = out_tdata[EST_W +: GAIN_W];
  assign in_xfer = in_tvalid && in_tready;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready && !$rose(out_tvalid))
    else $error("core not busy after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!gain_w[FRAC_BITS] || (gain_w[FRAC_BITS-1:0] == '0)))
    else $error("gain above one");

endmodule

bind scalar_kalman_filter_core skf_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_skf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

@@ tb/tb_scalar_kalman_filter_core.sv @@
// testbench for the scalar kalman filter core: directed and random samples checked against a predictor
`timescale 1ns / 1ps
module tb_scalar_kalman_filter_core;

  localparam int SAMPLE_W = 12;
  localparam int FRAC_W   = 16;
  localparam int EST_W    = SAMPLE_W + FRAC_W;
  localparam int GAIN_W   = FRAC_W + 1;
  localparam int COV_W    = skf_pkg::COV_W;
  localparam int IN_TW    = 16;
  localparam int OUT_TW   = 80;
  localparam int DRAIN_CYCLES = 64;

  localparam logic [63:0] ONE_FIX  = 64'd1 << FRAC_W;
  localparam logic [63:0] HALF_FIX = 64'd1 << (FRAC_W - 1);
  localparam logic [63:0] COV_MAX  = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [EST_W-1:0]  estimate;
    logic [GAIN_W-1:0] gain;
    logic [COV_W-1:0]  covariance;
  } kf_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;  // measurement
  logic [0:0] in_tuser = '0;        // restart
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;     // estimate, gain, covariance
  logic cfg_we = 1'b0;
  logic [skf_pkg::REG_IDX_W-1:0] cfg_addr = skf_pkg::REG_PROCESS_NOISE;
  logic [COV_W-1:0] cfg_data = '0;

  // filter state and registers as the block should hold them
  logic [COV_W-1:0] q_noise;
  logic [COV_W-1:0] r_noise;
  logic [COV_W-1:0] p_init;
  logic [EST_W-1:0] x_init;
  logic [EST_W-1:0] est_state;
  logic [COV_W-1:0] cov_state;

  kf_result_t predicted_outputs[$];
  int errors = 0;
  int burst_left = 0;
  int stall_cnt = 0;

  scalar_kalman_filter_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic kf_result_t kalman_step(input logic [SAMPLE_W-1:0] meas, input logic restart);
    logic [63:0] pp, den, gain, target, x, mag, step, p_next;
    kf_result_t res;
    if (restart) begin
      est_state = x_init;
      cov_state = p_init;
    end
    pp = 64'(cov_state) + 64'(q_noise);
    if (pp > COV_MAX) pp = COV_MAX;
    den = pp + 64'(r_noise);
    gain = (den == 0) ? 64'd0 : (pp << FRAC_W) / den;
    x = 64'(est_state);
    target = 64'({meas, {FRAC_W{1'b0}}});
    mag = (target >= x) ? target - x : x - target;
    step = (gain * mag + HALF_FIX) >> FRAC_W;
    if (step > mag) step = mag;
    x = (target >= x) ? x + step : x - step;
    p_next = ((ONE_FIX - gain) * pp + HALF_FIX) >> FRAC_W;
    est_state = x[EST_W-1:0];
    cov_state = p_next[COV_W-1:0];
    res.estimate = est_state;
    res.gain = gain[GAIN_W-1:0];
    res.covariance = cov_state;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    kf_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (predicted_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
        errors++;
      end else begin
        want = predicted_outputs.pop_front();
        check_field("estimate", 32'(want.estimate), 32'(out_tdata[EST_W-1:0]));
        check_field("gain", 32'(want.gain), 32'(out_tdata[EST_W +: GAIN_W]));
        check_field("covariance", want.covariance, out_tdata[EST_W+GAIN_W +: COV_W]);
      end
    end
  end

  // receiver stall pattern: short stalls, long open stretches, and jitter
  always @(posedge clk) begin : receiver_stalls
    int mode;
    if (stall_cnt == 0) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        out_tready <= 1'b0;
        stall_cnt = $urandom_range(1, 30);
      end else if (mode < 4) begin
        out_tready <= 1'b1;
        stall_cnt = $urandom_range(100, 400);
      end else begin
        out_tready <= 1'($urandom_range(0, 1));
        stall_cnt = $urandom_range(1, 8);
      end
    end else begin
      stall_cnt--;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] meas, input logic restart);
    in_tvalid <= 1'b1;
    in_tdata <= IN_TW'(meas);
    in_tuser <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted_outputs.push_back(kalman_step(meas, restart));
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle;
    in_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] q, input logic [31:0] r,
                              input logic [31:0] p0, input logic [31:0] x0);
    logic [skf_pkg::REG_IDX_W-1:0] idx [4];
    logic [31:0] vals [4];
    idx = '{skf_pkg::REG_PROCESS_NOISE, skf_pkg::REG_MEASUREMENT_NOISE,
            skf_pkg::REG_INITIAL_COVARIANCE, skf_pkg::REG_INITIAL_ESTIMATE};
    vals = '{q, r, p0, x0};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    q_noise = q;
    r_noise = r;
    p_init = p0;
    x_init = x0[EST_W-1:0];
  endtask

  function automatic logic [31:0] pick_noise;
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0002_0000);
      3: return $urandom_range(0, 32'h0100_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample;
    int near;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: begin
        near = int'(est_state[EST_W-1:FRAC_W]) + $urandom_range(0, 4) - 2;
        if (near < 0) near = 0;
        if (near > 4095) near = 4095;
        return near[SAMPLE_W-1:0];
      end
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic test_reset_defaults;
    send_sample(12'd800, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd800, 1'b1);
  endtask

  task automatic test_predict_saturation;
    program_regs(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(12'd0, 1'b1);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    // no measurement noise: full gain, estimate lands on the sample
    program_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b0);
  endtask

  task automatic test_zero_denominator;
    program_regs(32'd0, 32'd0, 32'd0, $urandom);
    send_sample(12'd4095, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(12'd123, 1'b0);
  endtask

  task automatic test_rounding_halves;
    // gain of one half makes the step land on a half in both directions
    program_regs(32'd0, 32'h0001_0000, 32'h0001_0000, 32'd1);
    send_sample(12'd0, 1'b1);
    program_regs(32'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0001);
    send_sample(12'd2, 1'b1);
    send_sample(12'd1, 1'b1);
  endtask

  task automatic test_random_phases;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: program_regs(32'd0, 32'd0, 32'd0, 32'd0);
        2: program_regs(32'd0, 32'd0, $urandom, $urandom);
        3: program_regs(32'h0001_0000, 32'h000A_0000, 32'h0001_0000, 32'h0320_0000);
        default: program_regs(pick_noise(), pick_noise(), pick_noise(), $urandom);
      endcase
      for (int n = 0; n < 130; n++) begin
        send_sample(pick_sample(), (n == 0) || ($urandom_range(0, 11) == 0));
      end
    end
  endtask

  initial begin
    q_noise = 32'(skf_pkg::RST_Q_UNITS) << FRAC_W;
    r_noise = 32'(skf_pkg::RST_R_UNITS) << FRAC_W;
    p_init = 32'(skf_pkg::RST_P_UNITS) << FRAC_W;
    x_init = EST_W'(skf_pkg::RST_X_UNITS) << FRAC_W;
    est_state = x_init;
    cov_state = p_init;
    burst_left = $urandom_range(1, 6);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_predict_saturation();
    test_zero_denominator();
    test_rounding_halves();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/skf_pkg.sv
sv/skf_alu.sv
sv/scalar_kalman_filter_core.sv
sv/skf_checker.sv
tb/tb_scalar_kalman_filter_core.sv
